[src/bqsr_pkg.sv]
// ============================================================================
// bqsr_pkg: shared types and constants of the biquadratic surface renderer
// Fixed widths, register index codes and the Q.16 product helper; the widths
// serve the coordinate normalizer, and all of them the top-level pipeline.
// ============================================================================
`default_nettype none

package bqsr_pkg;

  // Coordinate and frame-size widths.
  localparam int POS_W    = 12;
  localparam int SIDE_W   = 13;
  localparam int MAX_SIDE = 4096;

  // Normalized coordinates and monomials are signed Q1.16 in 18 bits.
  localparam int NORM_FRAC = 16;
  localparam int NQ_W      = 18;
  localparam int QUO_W     = NORM_FRAC + 1;

  // Normalizer: one setup stage, four quotient stages, one finishing stage.
  localparam int NORM_STAGES = 6;

  // Coefficients: signed Q7.10, three per 54-bit register.
  localparam int COEFF_BITS  = 18;
  localparam int COEFF_REG_W = 54;
  localparam int CFG_IDX_W   = 3;

  // Result: signed Q13.10.
  localparam int OUT_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFFS_Y0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFFS_Y1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFFS_Y2    = 3'd4;

  typedef logic signed [NQ_W-1:0] norm_t;

  localparam norm_t NORM_ONE = norm_t'(1) <<< NORM_FRAC;

  // Product of two Q.16 values, rounded half up back to Q.16. All operands
  // stay within [-1, 1], so the rounded result always fits in norm_t.
  function automatic norm_t qmul(input norm_t a, input norm_t b);
    logic signed [2*NQ_W-1:0] prod;
    logic signed [2*NQ_W-1:0] rnd;
    prod = a * b;
    rnd  = prod + ((2*NQ_W)'(1) <<< (NORM_FRAC - 1));
    return rnd[NORM_FRAC +: NQ_W];
  endfunction

endpackage

`default_nettype wire

[src/biquadratic_surface_render.sv]
// ============================================================================
// biquadratic_surface_render: nine-term polynomial surface evaluator
// Normalizes a pixel coordinate onto the unit square and evaluates
// sum c[b][a] * x^a * y^b for a, b in 0..2, giving a saturated Q13.10 value.
// ============================================================================
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in_     | input     | in_valid / in_ready  | pixel_column, pixel_row
//   out_    | output    | out_valid/ out_ready | surface_value (Q13.10), saturated
//   cfg_    | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One transaction is accepted per cycle while out_ready is high or some stage is empty. Its result
// passes through 11 register stages: a six-stage normalizer whose 17-bit restoring divider
// resolves four quotient bits per stage, two monomial stages, one coefficient multiply stage
// and a two-level adder tree ending in the output register. Reset (rst_n low, synchronous)
// empties the pipeline, holds in_ready low, sets both frame sizes to 1 and clears the
// coefficients. A stalled output holds every full stage while empty stages keep filling.
`default_nettype none

module biquadratic_surface_render (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // Input channel.
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [bqsr_pkg::POS_W-1:0]              in_pixel_column,
  input  wire logic [bqsr_pkg::POS_W-1:0]              in_pixel_row,
  // Result channel.
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [bqsr_pkg::OUT_W-1:0]            out_surface_value,
  output logic                                         out_saturated,
  // Configuration port.
  input  wire logic                                    cfg_we,
  input  wire logic [bqsr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [bqsr_pkg::COEFF_REG_W-1:0]        cfg_wdata
);
  import bqsr_pkg::*;

  // Stage numbering: 1..6 normalizer, 7 and 8 monomials, 9 coefficient
  // products, 10 partial sums, 11 final sum and output register.
  localparam int S_MONO1 = NORM_STAGES + 1;
  localparam int S_MONO2 = NORM_STAGES + 2;
  localparam int S_PROD  = NORM_STAGES + 3;
  localparam int S_PSUM  = NORM_STAGES + 4;
  localparam int S_OUT   = NORM_STAGES + 5;

  localparam int PROD_W = 2 * NQ_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int ACC_W  = PSUM_W + 2;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (NORM_FRAC - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX_W = ACC_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN_W = -OUT_MAX_W - ACC_W'(1);

  // --------------------------------------------------------------------------
  // Configuration registers. Frame sizes are stored already clamped to the
  // usable range, so a size of 0 reads as 1 and anything above the largest
  // side reads as that side.
  // --------------------------------------------------------------------------
  logic [SIDE_W-1:0]       side_x_r;
  logic [SIDE_W-1:0]       side_y_r;
  logic [COEFF_REG_W-1:0]  coeff_r [3];
  logic [SIDE_W-1:0]       side_wr;

  always_comb begin
    side_wr = cfg_wdata[SIDE_W-1:0];
    if (side_wr == '0) begin
      side_wr = SIDE_W'(1);
    end else if (side_wr > SIDE_W'(MAX_SIDE)) begin
      side_wr = SIDE_W'(MAX_SIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_x_r   <= SIDE_W'(1);
      side_y_r   <= SIDE_W'(1);
      coeff_r[0] <= '0;
      coeff_r[1] <= '0;
      coeff_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  side_x_r   <= side_wr;
        REG_FRAME_HEIGHT: side_y_r   <= side_wr;
        REG_COEFFS_Y0:    coeff_r[0] <= cfg_wdata;
        REG_COEFFS_Y1:    coeff_r[1] <= cfg_wdata;
        REG_COEFFS_Y2:    coeff_r[2] <= cfg_wdata;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Each stage carries a valid bit; a stage loads when it
  // is empty or when the stage after it loads, so bubbles close up under a
  // stalled output. The ready chain runs combinationally from out_ready
  // back to in_ready.
  // --------------------------------------------------------------------------
  logic [S_OUT:1] vld_r;
  logic [S_OUT:1] stg_en;

  always_comb begin
    stg_en[S_OUT] = !vld_r[S_OUT] || out_ready;
    for (int k = S_OUT - 1; k >= 1; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign in_ready = rst_n && stg_en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= S_OUT; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1..6: both coordinates are normalized in parallel. Stages 1..5
  // read the frame sizes directly; the user must change them only while
  // the pipeline is empty, as the block itself does not enforce it.
  // --------------------------------------------------------------------------
  norm_t x_q;
  norm_t y_q;

  bqsr_norm u_norm_x (
    .clk    (clk),
    .stg_en (stg_en[NORM_STAGES:1]),
    .pos    (in_pixel_column),
    .side   (side_x_r),
    .q      (x_q)
  );

  bqsr_norm u_norm_y (
    .clk    (clk),
    .stg_en (stg_en[NORM_STAGES:1]),
    .pos    (in_pixel_row),
    .side   (side_y_r),
    .q      (y_q)
  );

  // --------------------------------------------------------------------------
  // Stage 7: second-order monomials x^2, y^2 and x*y.
  // --------------------------------------------------------------------------
  norm_t x7_r, y7_r, x2_7_r, y2_7_r, xy7_r;

  always_ff @(posedge clk) begin
    if (stg_en[S_MONO1]) begin
      x7_r   <= x_q;
      y7_r   <= y_q;
      x2_7_r <= qmul(x_q, x_q);
      y2_7_r <= qmul(y_q, y_q);
      xy7_r  <= qmul(x_q, y_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: higher monomials x^2*y, x*y^2 and x^2*y^2, each built from the
  // rounded stage-7 values exactly as the surface definition rounds them.
  // --------------------------------------------------------------------------
  norm_t x8_r, y8_r, x2_8_r, y2_8_r, xy8_r, x2y8_r, xy2_8_r, x2y2_8_r;

  always_ff @(posedge clk) begin
    if (stg_en[S_MONO2]) begin
      x8_r     <= x7_r;
      y8_r     <= y7_r;
      x2_8_r   <= x2_7_r;
      y2_8_r   <= y2_7_r;
      xy8_r    <= xy7_r;
      x2y8_r   <= qmul(x2_7_r, y7_r);
      xy2_8_r  <= qmul(x7_r, y2_7_r);
      x2y2_8_r <= qmul(x2_7_r, y2_7_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: the nine coefficient-by-monomial products, kept exact.
  // Coefficient a of register b sits at bits a*COEFF_BITS upward.
  // --------------------------------------------------------------------------
  norm_t mono [3][3];

  always_comb begin
    mono[0][0] = NORM_ONE;
    mono[0][1] = x8_r;
    mono[0][2] = x2_8_r;
    mono[1][0] = y8_r;
    mono[1][1] = xy8_r;
    mono[1][2] = x2y8_r;
    mono[2][0] = y2_8_r;
    mono[2][1] = xy2_8_r;
    mono[2][2] = x2y2_8_r;
  end

  logic signed [PROD_W-1:0] prod_r [3][3];

  for (genvar b = 0; b < 3; b++) begin : g_row
    for (genvar a = 0; a < 3; a++) begin : g_col
      logic signed [COEFF_BITS-1:0] coef;

      assign coef = $signed(coeff_r[b][a*COEFF_BITS +: COEFF_BITS]);

      always_ff @(posedge clk) begin
        if (stg_en[S_PROD]) begin
          prod_r[b][a] <= coef * mono[b][a];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: one partial sum per power of y.
  // --------------------------------------------------------------------------
  logic signed [PSUM_W-1:0] psum_r [3];

  always_ff @(posedge clk) begin
    if (stg_en[S_PSUM]) begin
      for (int b = 0; b < 3; b++) begin
        psum_r[b] <= PSUM_W'(prod_r[b][0]) + PSUM_W'(prod_r[b][1])
                   + PSUM_W'(prod_r[b][2]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: final sum, round half up from 26 to 10 fraction bits, clip to
  // the Q13.10 range and flag any clipping. This is the output register.
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [OUT_W-1:0] value_nxt;
  logic                    sat_nxt;

  always_comb begin
    acc     = ACC_W'(psum_r[0]) + ACC_W'(psum_r[1]) + ACC_W'(psum_r[2]);
    acc_rnd = (acc + RND_HALF) >>> NORM_FRAC;
    if (acc_rnd > OUT_MAX_W) begin
      value_nxt = OUT_MAX_W[OUT_W-1:0];
      sat_nxt   = 1'b1;
    end else if (acc_rnd < OUT_MIN_W) begin
      value_nxt = OUT_MIN_W[OUT_W-1:0];
      sat_nxt   = 1'b1;
    end else begin
      value_nxt = acc_rnd[OUT_W-1:0];
      sat_nxt   = 1'b0;
    end
  end

  logic signed [OUT_W-1:0] value_r;
  logic                    sat_r;

  always_ff @(posedge clk) begin
    if (stg_en[S_OUT]) begin
      value_r <= value_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid         = vld_r[S_OUT];
  assign out_surface_value = value_r;
  assign out_saturated     = sat_r;

endmodule

`default_nettype wire

[src/bqsr_norm.sv]
// ============================================================================
// bqsr_norm: pipelined coordinate normalizer
// Maps a pixel index onto [-1, 1) as floor((2*pos - side) * 2^16 / side),
// using a restoring divider spread over the pipeline, four quotient bits a
// stage. Stage enables come from the owner of the valid bits.
// ============================================================================
`default_nettype none

module bqsr_norm (
  input  wire logic                              clk,
  input  wire logic [bqsr_pkg::NORM_STAGES-1:0]  stg_en,
  input  wire logic [bqsr_pkg::POS_W-1:0]        pos,
  input  wire logic [bqsr_pkg::SIDE_W-1:0]       side,
  output bqsr_pkg::norm_t                        q
);
  import bqsr_pkg::*;

  localparam int DIV_STAGES = NORM_STAGES - 2;
  localparam int BITS_PER   = (QUO_W - 1) / DIV_STAGES;

  // Several shift-compare-subtract steps of the restoring divider.
  function automatic logic [SIDE_W+BITS_PER-1:0] div_step(
    input logic [SIDE_W-1:0] rem_in,
    input logic [SIDE_W-1:0] dvs
  );
    logic [SIDE_W:0]       r;
    logic [SIDE_W-1:0]     rem;
    logic [BITS_PER-1:0]   bits;
    rem  = rem_in;
    bits = '0;
    for (int i = BITS_PER - 1; i >= 0; i--) begin
      r = {rem, 1'b0};
      if (r >= {1'b0, dvs}) begin
        bits[i] = 1'b1;
        r       = r - {1'b0, dvs};
      end
      rem = r[SIDE_W-1:0];
    end
    return {rem, bits};
  endfunction

  logic                ge_r   [DIV_STAGES+1];
  logic                neg_r  [DIV_STAGES+1];
  logic [SIDE_W-1:0]   rem_r  [DIV_STAGES+1];
  logic [QUO_W-1:0]    quo_r  [DIV_STAGES+1];
  norm_t               q_r;

  // Setup stage: signed distance from the center, its magnitude, and the
  // integer quotient bit (set when the magnitude is at least the side).
  logic [SIDE_W:0]     dif;
  logic [SIDE_W-1:0]   mag;
  logic                top_bit;

  always_comb begin
    dif     = {1'b0, pos, 1'b0} - {1'b0, side};
    mag     = dif[SIDE_W] ? SIDE_W'(~dif + 1'b1) : dif[SIDE_W-1:0];
    top_bit = (mag >= side);
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      ge_r[0]  <= ({1'b0, pos} >= side);
      neg_r[0] <= dif[SIDE_W];
      rem_r[0] <= top_bit ? (mag - side) : mag;
      quo_r[0] <= QUO_W'(top_bit);
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [SIDE_W+BITS_PER-1:0] step;

    assign step = div_step(rem_r[k-1], side);

    always_ff @(posedge clk) begin
      if (stg_en[k]) begin
        ge_r[k]  <= ge_r[k-1];
        neg_r[k] <= neg_r[k-1];
        rem_r[k] <= step[BITS_PER +: SIDE_W];
        quo_r[k] <= {quo_r[k-1][QUO_W-BITS_PER-1:0], step[BITS_PER-1:0]};
      end
    end
  end

  // Finishing stage: negative distances round toward minus infinity, and a
  // pixel at or beyond the frame edge pins just below +1.
  norm_t q_nxt;

  always_comb begin
    if (ge_r[DIV_STAGES]) begin
      q_nxt = NORM_ONE - norm_t'(1);
    end else if (neg_r[DIV_STAGES]) begin
      q_nxt = -(norm_t'(quo_r[DIV_STAGES]) + norm_t'(rem_r[DIV_STAGES] != '0));
    end else begin
      q_nxt = norm_t'(quo_r[DIV_STAGES]);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[NORM_STAGES-1]) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

[tb/sv/tb_biquadratic_surface_render.sv]
// ============================================================================
// tb_biquadratic_surface_render: self-checking bench for the surface renderer
// Drives pixel coordinates through a valid/ready channel, predicts each
// surface value in Q13.10 from its own copy of the frame sizes and the
// coefficients, and compares every returned transaction field by field.
// ============================================================================

module tb_biquadratic_surface_render;
  timeunit 1ns;
  timeprecision 1ps;

  import bqsr_pkg::*;

  // Bench timing and run length.
  localparam int PIPE_LATENCY = 11;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_GAP = 18;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  // Random part: phases of pixels, each under its own register settings.
  localparam int PHASES = 10;
  localparam int PIXELS_PER_PHASE = 70;
  localparam int HOLD_PHASE = 3;
  localparam int DRAIN_PHASE = 6;

  // Fixed-point constants of the evaluation.
  localparam longint UNIT_Q16 = 64'sd65536;
  localparam longint HALF_Q16 = 64'sd32768;
  localparam longint OUT_HIGH = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LOW = -(64'sd1 <<< (OUT_W - 1));

  // Register indexes that decode to nothing; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] NO_REG = REG_FRAME_WIDTH;

  // Coefficient patterns; a register holds {c2, c1, c0} with c0 lowest.
  localparam logic [COEFF_BITS-1:0] C_MAX = 18'h1FFFF;
  localparam logic [COEFF_BITS-1:0] C_MIN = 18'h20000;
  localparam logic [COEFF_BITS-1:0] C_ZERO = 18'h00000;
  localparam logic [COEFF_REG_W-1:0] ALL_ONES = '1;
  localparam logic [COEFF_REG_W-1:0] ALL_MAX = {C_MAX, C_MAX, C_MAX};
  localparam logic [COEFF_REG_W-1:0] ALL_MIN = {C_MIN, C_MIN, C_MIN};
  localparam logic [COEFF_REG_W-1:0] MIX_Y0 = {18'h00400, 18'h2AAAA, 18'h15555};
  localparam logic [COEFF_REG_W-1:0] MIX_Y1 = {18'h3FC00, 18'h00800, 18'h1FFFF};
  localparam logic [COEFF_REG_W-1:0] MIX_Y2 = {18'h20001, 18'h0F0F0, 18'h3FFFF};

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    clipped;
  } surface_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  // One line of the directed table: either a register write or a pixel.
  // When typed is set, the expected value is given in the table itself.
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    index;
    logic [COEFF_REG_W-1:0]  data;
    logic [POS_W-1:0]        pix_col;
    logic [POS_W-1:0]        pix_row;
    logic                    typed;
    logic signed [OUT_W-1:0] value;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 42;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Straight out of reset: width and height 1, every coefficient zero.
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd0, 1'b1, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd4095, 12'd4095, 1'b1, 24'sd0},
    // Writes to indexes that do not exist change nothing.
    '{ROW_WRITE, REG_SPARE_5, ALL_ONES, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_SPARE_7, ALL_ONES, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd1, 12'd0, 1'b1, 24'sd0},
    // Zero width acts as one, an oversized height as the largest side.
    '{ROW_WRITE, REG_FRAME_WIDTH, '0, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, ALL_ONES, 12'd0, 12'd0, 1'b0, 24'sd0},
    // Constant term alone at both extremes.
    '{ROW_WRITE, REG_COEFFS_Y0, {C_ZERO, C_ZERO, C_MAX}, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd0, 1'b1, 24'sd131071},
    '{ROW_PIXEL, NO_REG, '0, 12'd4095, 12'd4095, 1'b1, 24'sd131071},
    '{ROW_WRITE, REG_COEFFS_Y0, {C_ZERO, C_ZERO, C_MIN}, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd4095, 1'b1, -24'sd131072},
    // Linear term in x across the full width.
    '{ROW_WRITE, REG_FRAME_WIDTH, 54'd4096, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y0, {C_ZERO, C_MAX, C_ZERO}, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd0, 1'b1, -24'sd131071},
    '{ROW_PIXEL, NO_REG, '0, 12'd2048, 12'd0, 1'b1, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd4095, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd1, 12'd0, 1'b0, 24'sd0},
    // Every coefficient at its largest value.
    '{ROW_WRITE, REG_COEFFS_Y0, ALL_MAX, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y1, ALL_MAX, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y2, ALL_MAX, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 54'd4096, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd0, 1'b1, 24'sd131071},
    '{ROW_PIXEL, NO_REG, '0, 12'd2048, 12'd2048, 1'b1, 24'sd131071},
    '{ROW_PIXEL, NO_REG, '0, 12'd4095, 12'd4095, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd4095, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd4095, 1'b0, 24'sd0},
    // Every coefficient at its most negative value.
    '{ROW_WRITE, REG_COEFFS_Y0, ALL_MIN, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y1, ALL_MIN, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y2, ALL_MIN, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd0, 1'b1, -24'sd131072},
    '{ROW_PIXEL, NO_REG, '0, 12'd4095, 12'd4095, 1'b0, 24'sd0},
    // Odd small frame with mixed coefficients; some pixels lie outside it.
    '{ROW_WRITE, REG_FRAME_WIDTH, 54'd3, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 54'd5, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y0, MIX_Y0, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y1, MIX_Y1, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_WRITE, REG_COEFFS_Y2, MIX_Y2, 12'd0, 12'd0, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd1, 12'd2, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd2, 12'd4, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd3, 12'd5, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd100, 12'd7, 1'b0, 24'sd0},
    '{ROW_PIXEL, NO_REG, '0, 12'd0, 12'd0, 1'b0, 24'sd0}
  };

  // Clock, reset and the signals of the block. Every input starts known.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [POS_W-1:0] in_pixel_column = '0;
  logic [POS_W-1:0] in_pixel_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_surface_value;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_REG_W-1:0] cfg_wdata = '0;

  // The bench's own copy of the register file, as it stands after reset.
  logic [SIDE_W-1:0] width_reg = SIDE_W'(1);
  logic [SIDE_W-1:0] height_reg = SIDE_W'(1);
  logic [COEFF_REG_W-1:0] coeff_reg [3] = '{'0, '0, '0};

  // Surface values still owed by the block, oldest first.
  surface_t surface_q[$];
  int error_count = 0;
  int cycle_count = 0;

  // Shared between the sender and the receiver: whether either side runs
  // without gaps in the current phase, and a request for one long hold-off.
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit hold_output = 1'b0;

  biquadratic_surface_render dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_column  (in_pixel_column),
    .in_pixel_row     (in_pixel_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_surface_value(out_surface_value),
    .out_saturated    (out_saturated),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A side of zero counts as one, and anything past the largest frame side is
  // treated as that side.
  function automatic longint frame_side(input logic [SIDE_W-1:0] side_reg);
    longint side;
    side = longint'(side_reg);
    if (side == 0) side = 1;
    if (side > MAX_SIDE) side = MAX_SIDE;
    return side;
  endfunction

  // Maps a pixel index onto [-1, 1) in Q1.16, rounding toward minus infinity.
  // Pixels at or beyond the frame edge pin just below +1.
  function automatic longint unit_coord(input logic [POS_W-1:0] pos,
                                        input logic [SIDE_W-1:0] side_reg);
    longint side;
    longint num;
    longint q;
    side = frame_side(side_reg);
    num = (2 * longint'(pos) - side) * UNIT_Q16;
    if (num >= 0) begin
      q = num / side;
    end else begin
      q = -((-num + side - 1) / side);
    end
    if (q > UNIT_Q16 - 1) q = UNIT_Q16 - 1;
    if (q < -UNIT_Q16) q = -UNIT_Q16;
    return q;
  endfunction

  // Q.16 times Q.16 back to Q.16, rounding half up.
  function automatic longint q16_product(input longint a, input longint b);
    return (a * b + HALF_Q16) >>> 16;
  endfunction

  // Expected Q13.10 value of the surface at one pixel under the current
  // register settings.
  function automatic surface_t render_surface(input logic [POS_W-1:0] col,
                                              input logic [POS_W-1:0] row);
    longint x;
    longint y;
    longint x2;
    longint y2;
    longint mono [3][3];
    longint acc;
    longint res;
    logic signed [COEFF_BITS-1:0] coeff;
    surface_t result;
    x = unit_coord(col, width_reg);
    y = unit_coord(row, height_reg);
    x2 = q16_product(x, x);
    y2 = q16_product(y, y);
    mono[0][0] = UNIT_Q16;
    mono[0][1] = x;
    mono[0][2] = x2;
    mono[1][0] = y;
    mono[1][1] = q16_product(x, y);
    mono[1][2] = q16_product(x2, y);
    mono[2][0] = y2;
    mono[2][1] = q16_product(x, y2);
    mono[2][2] = q16_product(x2, y2);
    acc = 0;
    for (int b = 0; b < 3; b++) begin
      for (int a = 0; a < 3; a++) begin
        coeff = coeff_reg[b][a*COEFF_BITS +: COEFF_BITS];
        acc += longint'(coeff) * mono[b][a];
      end
    end
    res = (acc + HALF_Q16) >>> 16;
    result.clipped = 1'b0;
    if (res > OUT_HIGH) begin
      res = OUT_HIGH;
      result.clipped = 1'b1;
    end
    if (res < OUT_LOW) begin
      res = OUT_LOW;
      result.clipped = 1'b1;
    end
    result.value = res[OUT_W-1:0];
    return result;
  endfunction

  // ---------------------------------------------------------------------------
  // Random values for the register settings
  // ---------------------------------------------------------------------------

  function automatic logic [COEFF_REG_W-1:0] random_word();
    return COEFF_REG_W'({$urandom(), $urandom()});
  endfunction

  // Frame sides lean on the corners: zero, one, tiny, the full side and
  // values past it, with random junk in the bits above the register.
  function automatic logic [COEFF_REG_W-1:0] random_side_word();
    logic [COEFF_REG_W-1:0] word;
    word = random_word();
    case ($urandom_range(0, 5))
      0: word[SIDE_W-1:0] = '0;
      1: word[SIDE_W-1:0] = SIDE_W'(MAX_SIDE);
      2: word[SIDE_W-1:0] = SIDE_W'($urandom_range(MAX_SIDE + 1, (1 << SIDE_W) - 1));
      3: word[SIDE_W-1:0] = SIDE_W'($urandom_range(1, 16));
      default: word[SIDE_W-1:0] = SIDE_W'($urandom_range(1, MAX_SIDE));
    endcase
    return word;
  endfunction

  // Each coefficient is its largest, its most negative or a random value.
  function automatic logic [COEFF_REG_W-1:0] random_coeffs();
    logic [COEFF_REG_W-1:0] word;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 3))
        0: word[a*COEFF_BITS +: COEFF_BITS] = C_MAX;
        1: word[a*COEFF_BITS +: COEFF_BITS] = C_MIN;
        default: word[a*COEFF_BITS +: COEFF_BITS] = COEFF_BITS'($urandom());
      endcase
    end
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving the block
  // ---------------------------------------------------------------------------

  // Writes one register of the block and the bench's copy of it. The enable
  // is high for a single cycle and is low again before the task returns, so
  // back-to-back writes never raise and lower it in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [COEFF_REG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_FRAME_WIDTH: width_reg = data[SIDE_W-1:0];
      REG_FRAME_HEIGHT: height_reg = data[SIDE_W-1:0];
      REG_COEFFS_Y0: coeff_reg[0] = data;
      REG_COEFFS_Y1: coeff_reg[1] = data;
      REG_COEFFS_Y2: coeff_reg[2] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one pixel and holds it until the block takes it. The handshake is
  // judged on the values that were present at the clock edge, so the
  // expectation is queued in the same cycle the transaction completes.
  task automatic offer_pixel(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row,
                             input logic typed, input logic signed [OUT_W-1:0] value);
    surface_t want;
    in_valid <= 1'b1;
    in_pixel_column <= col;
    in_pixel_row <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      want.value = value;
      want.clipped = 1'b0;
    end else begin
      want = render_surface(col, row);
    end
    surface_q.push_back(want);
  endtask

  // A gap of zero leaves valid high, so the next pixel follows directly.
  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every owed surface value has come back.
  // Each pixel yields exactly one result, so an empty queue means the
  // pipeline is empty, output register included.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (surface_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int sender_gap();
    return tx_eager ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Register writes wait until the block has gone idle.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        wait_for_results();
        write_reg(DIRECTED[i].index, DIRECTED[i].data);
      end else begin
        offer_pixel(DIRECTED[i].pix_col, DIRECTED[i].pix_row,
                    DIRECTED[i].typed, DIRECTED[i].value);
        pause_sender(sender_gap());
      end
    end

    // Random phases. Each one starts from an idle block with fresh settings.
    // The first pins the frame to its largest sides, the second to sides of 1 and 2.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      if (phase == 0) begin
        write_reg(REG_FRAME_WIDTH, COEFF_REG_W'(MAX_SIDE));
        write_reg(REG_FRAME_HEIGHT, COEFF_REG_W'(MAX_SIDE));
      end else if (phase == 1) begin
        write_reg(REG_FRAME_WIDTH, COEFF_REG_W'(1));
        write_reg(REG_FRAME_HEIGHT, COEFF_REG_W'(2));
      end else begin
        write_reg(REG_FRAME_WIDTH, random_side_word());
        write_reg(REG_FRAME_HEIGHT, random_side_word());
      end
      write_reg(REG_COEFFS_Y0, random_coeffs());
      write_reg(REG_COEFFS_Y1, random_coeffs());
      write_reg(REG_COEFFS_Y2, random_coeffs());
      // Now and then a stray write to an index that decodes to nothing.
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_COEFFS_Y2 + 1, (1 << CFG_IDX_W) - 1)),
                  random_word());
      end

      // In the hold phase the receiver stops for a long stretch while the
      // sender keeps pushing back to back, so the pipeline fills and the
      // block has to drop in_ready.
      tx_eager = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      rx_eager = (phase != HOLD_PHASE) && ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) hold_output = 1'b1;

      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        // Halfway through one phase the sender stops until all results are
        // back, then picks up again with the same settings.
        if (phase == DRAIN_PHASE && k == PIXELS_PER_PHASE / 2) wait_for_results();
        // Mostly pixels inside the frame; the rest anywhere, so the
        // beyond-the-edge clamp is hit as well.
        if ($urandom_range(0, 9) == 0) begin
          col = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end else begin
          col = POS_W'($urandom_range(0, frame_side(width_reg) - 1));
        end
        if ($urandom_range(0, 9) == 0) begin
          row = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end else begin
          row = POS_W'($urandom_range(0, frame_side(height_reg) - 1));
        end
        offer_pixel(col, row, 1'b0, '0);
        pause_sender(sender_gap());
      end
    end

    // Everything sent: collect the last results, then watch a little longer
    // for anything the block should not have produced.
    wait_for_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (error_count == 0 && surface_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: draws a wait before every result and raises ready afterwards.
  // A hold request from the sender turns one wait into a long stall.
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: each completed output transaction is matched against the
  // oldest expected surface value.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    surface_t want;
    if (rst_n && out_valid && out_ready) begin
      if (surface_q.size() == 0) begin
        $display("%0t: result with nothing expected, got value %0d saturated %0b",
                 $time, out_surface_value, out_saturated);
        error_count++;
      end else begin
        want = surface_q.pop_front();
        if (out_surface_value !== want.value) begin
          $display("%0t: surface value mismatch, expected %0d, got %0d",
                   $time, want.value, out_surface_value);
          error_count++;
        end
        if (out_saturated !== want.clipped) begin
          $display("%0t: saturated flag mismatch, expected %0b, got %0b",
                   $time, want.clipped, out_saturated);
          error_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
src/bqsr_pkg.sv
src/bqsr_norm.sv
src/biquadratic_surface_render.sv
tb/sv/tb_biquadratic_surface_render.sv
